// File: design/rerlc_pkg.sv
package rerlc_pkg;

   // Width of the press and step tick counters.
   localparam int TICK_COUNTER_BITS = 10;
   // Width used when a tick counter is compared with a 10-bit register.
   localparam int TICK_CMP_BITS = (TICK_COUNTER_BITS > 10) ? TICK_COUNTER_BITS : 10;

   localparam int LEVEL_BITS = 7;
   localparam int DRIVE_BITS = 8;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 7'd100;

   // level*255/100: the product is at most 15 bits; the divide by 100 is a
   // multiply by ceil(2^19/100) and a shift, exact for every 7-bit level.
   localparam int SCALE_PROD_BITS = 15;
   localparam int RECIP_SHIFT = 19;
   localparam logic [12:0] RECIP_100 = 13'd5243;

   localparam int CSR_DATA_BITS = 10;

   typedef enum logic [1:0] {
      CSR_PRESS_LOCKOUT = 2'd0,
      CSR_FAST_WINDOW   = 2'd1,
      CSR_FAST_STEP     = 2'd2,
      CSR_SLOW_STEP     = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      CHAN_RED   = 2'd0,
      CHAN_GREEN = 2'd1,
      CHAN_BLUE  = 2'd2
   } channel_type;

   typedef struct packed {
      logic button_level;
      logic enc_clock_level;
      logic enc_data_level;
   } req_payload_type;

   typedef struct packed {
      logic [DRIVE_BITS-1:0] red_drive;
      logic [DRIVE_BITS-1:0] green_drive;
      logic [DRIVE_BITS-1:0] blue_drive;
      logic [LEVEL_BITS-1:0] red_percent;
      logic [LEVEL_BITS-1:0] green_percent;
      logic [LEVEL_BITS-1:0] blue_percent;
      logic [1:0]            selected_channel;
      logic                  level_changed;
      logic                  selection_changed;
   } rsp_payload_type;

endpackage

// File: design/rerlc_drive_scale.sv
module rerlc_drive_scale (
   input  logic [rerlc_pkg::LEVEL_BITS-1:0] level,
   output logic [rerlc_pkg::DRIVE_BITS-1:0] drive
);

   localparam int ProdBits = rerlc_pkg::SCALE_PROD_BITS;
   localparam int WideBits = ProdBits + 13;

   logic [ProdBits-1:0] times_255;
   logic [WideBits-1:0] recip_prod;

   // x*255 = (x << 8) - x
   always_comb begin
      times_255  = (ProdBits'(level) << 8) - ProdBits'(level);
      recip_prod = WideBits'(times_255) * WideBits'(rerlc_pkg::RECIP_100);
      drive      = recip_prod[rerlc_pkg::RECIP_SHIFT +: rerlc_pkg::DRIVE_BITS];
   end

endmodule

// File: design/rotary_encoder_rgb_level_control.sv
// RGB level control driven by a push button and a rotary encoder.
//
// Request channel (req_valid / req_stall / req_data): one sample of the
// button, encoder clock and encoder data lines per 1 ms tick. A request is
// taken at a clock edge with req_valid high and req_stall low.
// Result channel (rsp_valid / rsp_stall / rsp_data): exactly one result per
// request, in order, with all three levels raw (0..100) and scaled to 0..255,
// the selected channel and the press / step event flags of that tick.
// Throughput: one request per cycle while req_stall is low; the state update
// for a tick is done in the cycle the request is taken, so back-to-back
// ticks chain directly. Stall: an output register plus one skid register
// decouple the two sides; req_stall rises only when both hold a result that
// has not been taken. Configuration (csr_write_en / csr_index / csr_wdata)
// is to be written by the user only while idle; the block does not enforce it.
// Reset (synchronous, active high) empties the output stages, clears both
// tick counters and all levels, selects red, sets the previous encoder clock
// high and loads the register defaults (300, 80, 5, 1).
module rotary_encoder_rgb_level_control (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rerlc_pkg::req_payload_type            req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rerlc_pkg::rsp_payload_type            rsp_data,
   input  logic                                  csr_write_en,
   input  logic [1:0]                            csr_index,
   input  logic [rerlc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int TickBits = rerlc_pkg::TICK_COUNTER_BITS;
   localparam int CmpBits  = rerlc_pkg::TICK_CMP_BITS;
   localparam int LvlBits  = rerlc_pkg::LEVEL_BITS;
   localparam logic [TickBits-1:0] TickMax = {TickBits{1'b1}};

   // configuration registers
   logic [9:0]         press_lockout_ff;
   logic [9:0]         fast_window_ff;
   logic [LvlBits-1:0] fast_step_ff;
   logic [LvlBits-1:0] slow_step_ff;

   // block state
   logic [TickBits-1:0] ticks_since_press_ff, ticks_since_press_in;
   logic [TickBits-1:0] ticks_since_step_ff, ticks_since_step_in;
   logic                previous_clock_ff, previous_clock_in;
   logic [1:0]          channel_select_ff, channel_select_in;
   logic [LvlBits-1:0]  levels_ff [3];
   logic [LvlBits-1:0]  levels_in [3];

   // output stage and skid stage
   logic                        out_valid_ff, out_valid_in;
   logic                        skid_valid_ff, skid_valid_in;
   rerlc_pkg::rsp_payload_type  out_data_ff, out_data_in;
   rerlc_pkg::rsp_payload_type  skid_data_ff, skid_data_in;

   logic                        req_take;
   logic                        rsp_take;
   logic                        press_ok;
   logic                        clock_fall;
   logic [1:0]                  cur_chan;
   logic [LvlBits-1:0]          step;
   logic [LvlBits-1:0]          cur_level;
   logic [LvlBits:0]            level_sum;
   logic [LvlBits-1:0]          new_level;
   logic [rerlc_pkg::DRIVE_BITS-1:0] drive [3];
   rerlc_pkg::rsp_payload_type  result;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Tick update. The press test goes first; the encoder then acts on the
   // channel selected after it. Both tests use start-of-tick counters.
   always_comb begin
      press_ok = !req_data.button_level
                 && (CmpBits'(ticks_since_press_ff) > CmpBits'(press_lockout_ff));

      channel_select_in    = channel_select_ff;
      ticks_since_press_in = ticks_since_press_ff;
      if (press_ok) begin
         ticks_since_press_in = '0;
         channel_select_in    = (channel_select_ff >= rerlc_pkg::CHAN_BLUE) ?
                                rerlc_pkg::CHAN_RED : channel_select_ff + 2'd1;
      end else if (ticks_since_press_ff != TickMax) begin
         ticks_since_press_in = ticks_since_press_ff + TickBits'(1);
      end

      cur_chan   = (channel_select_in > rerlc_pkg::CHAN_BLUE) ?
                   rerlc_pkg::CHAN_RED : channel_select_in;
      clock_fall = !req_data.enc_clock_level && previous_clock_ff;
      step       = (CmpBits'(ticks_since_step_ff) < CmpBits'(fast_window_ff)) ?
                   fast_step_ff : slow_step_ff;
      cur_level  = levels_ff[cur_chan];
      level_sum  = {1'b0, cur_level} + {1'b0, step};

      // clamp to 0..100
      if (req_data.enc_data_level) begin
         new_level = (level_sum > (LvlBits+1)'(rerlc_pkg::LEVEL_MAX)) ?
                     rerlc_pkg::LEVEL_MAX : level_sum[LvlBits-1:0];
      end else begin
         new_level = (step > cur_level) ? '0 : cur_level - step;
      end

      for (int i = 0; i < 3; i++) begin
         levels_in[i] = levels_ff[i];
         if (clock_fall && (cur_chan == 2'(i))) begin
            levels_in[i] = new_level;
         end
      end

      ticks_since_step_in = ticks_since_step_ff;
      if (clock_fall) begin
         ticks_since_step_in = '0;
      end else if (ticks_since_step_ff != TickMax) begin
         ticks_since_step_in = ticks_since_step_ff + TickBits'(1);
      end
      previous_clock_in = req_data.enc_clock_level;
   end

   rerlc_drive_scale u_scale_red   (.level(levels_in[0]), .drive(drive[0]));
   rerlc_drive_scale u_scale_green (.level(levels_in[1]), .drive(drive[1]));
   rerlc_drive_scale u_scale_blue  (.level(levels_in[2]), .drive(drive[2]));

   always_comb begin
      result.red_drive         = drive[0];
      result.green_drive       = drive[1];
      result.blue_drive        = drive[2];
      result.red_percent       = levels_in[0];
      result.green_percent     = levels_in[1];
      result.blue_percent      = levels_in[2];
      result.selected_channel  = channel_select_in;
      result.level_changed     = clock_fall;
      result.selection_changed = press_ok;
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_take) begin
            out_data_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff) begin
            out_data_in  = result;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
      if (reset) begin
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
         ticks_since_press_ff <= '0;
         ticks_since_step_ff  <= '0;
         previous_clock_ff    <= 1'b1;
         channel_select_ff    <= rerlc_pkg::CHAN_RED;
         for (int i = 0; i < 3; i++) begin
            levels_ff[i] <= '0;
         end
         press_lockout_ff <= 10'd300;
         fast_window_ff   <= 10'd80;
         fast_step_ff     <= 7'd5;
         slow_step_ff     <= 7'd1;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_take) begin
            ticks_since_press_ff <= ticks_since_press_in;
            ticks_since_step_ff  <= ticks_since_step_in;
            previous_clock_ff    <= previous_clock_in;
            channel_select_ff    <= channel_select_in;
            for (int i = 0; i < 3; i++) begin
               levels_ff[i] <= levels_in[i];
            end
         end
         if (csr_write_en) begin
            case (rerlc_pkg::csr_index_type'(csr_index))
               rerlc_pkg::CSR_PRESS_LOCKOUT: press_lockout_ff <= csr_wdata;
               rerlc_pkg::CSR_FAST_WINDOW:   fast_window_ff   <= csr_wdata;
               rerlc_pkg::CSR_FAST_STEP:     fast_step_ff     <= csr_wdata[LvlBits-1:0];
               rerlc_pkg::CSR_SLOW_STEP:     slow_step_ff     <= csr_wdata[LvlBits-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: sim/rgb_level_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register ports of the RGB level block.
// Predicts each tick's levels, compares every accepted result in order and
// counts mismatches.
module rgb_level_checker
   import rerlc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_payload_type          req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_payload_type          rsp_data,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatch_count,
   output int                       ticks_pending
);

   // register copies
   logic [9:0] lockout_cfg;
   logic [9:0] window_cfg;
   logic [6:0] fast_cfg;
   logic [6:0] slow_cfg;

   // block state copies
   logic [TICK_COUNTER_BITS-1:0] press_age;
   logic [TICK_COUNTER_BITS-1:0] step_age;
   logic                         last_clock;
   channel_type                  active_chan;
   logic [LEVEL_BITS-1:0]        levels [3];

   rsp_payload_type expected_levels [$];
   rsp_payload_type predicted;
   rsp_payload_type oldest;

   function automatic logic [7:0] drive_level(input logic [LEVEL_BITS-1:0] pct);
      return 8'((int'(pct) * 255) / 100);
   endfunction

   task automatic apply_tick(input req_payload_type s, output rsp_payload_type r);
      int lvl;
      int step;
      logic sel_hit;
      logic lvl_hit;
      sel_hit = 1'b0;
      lvl_hit = 1'b0;
      // press test on the start-of-tick counter
      if (!s.button_level && press_age > lockout_cfg) begin
         press_age = '0;
         case (active_chan)
            CHAN_RED:   active_chan = CHAN_GREEN;
            CHAN_GREEN: active_chan = CHAN_BLUE;
            default:    active_chan = CHAN_RED;
         endcase
         sel_hit = 1'b1;
      end else if (press_age != '1) begin
         press_age++;
      end
      // falling encoder clock moves the channel selected after the press test
      if (!s.enc_clock_level && last_clock) begin
         step = (step_age < window_cfg) ? int'(fast_cfg) : int'(slow_cfg);
         lvl = int'(levels[active_chan]);
         if (s.enc_data_level) lvl += step;
         else lvl -= step;
         if (lvl < 0) lvl = 0;
         if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
         levels[active_chan] = LEVEL_BITS'(lvl);
         step_age = '0;
         lvl_hit = 1'b1;
      end else if (step_age != '1) begin
         step_age++;
      end
      last_clock = s.enc_clock_level;

      r.red_drive         = drive_level(levels[CHAN_RED]);
      r.green_drive       = drive_level(levels[CHAN_GREEN]);
      r.blue_drive        = drive_level(levels[CHAN_BLUE]);
      r.red_percent       = levels[CHAN_RED];
      r.green_percent     = levels[CHAN_GREEN];
      r.blue_percent      = levels[CHAN_BLUE];
      r.selected_channel  = active_chan;
      r.level_changed     = lvl_hit;
      r.selection_changed = sel_hit;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lockout_cfg = 10'd300;
         window_cfg  = 10'd80;
         fast_cfg    = 7'd5;
         slow_cfg    = 7'd1;
         press_age   = '0;
         step_age    = '0;
         last_clock  = 1'b1;
         active_chan = CHAN_RED;
         levels      = '{default: '0};
         expected_levels.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PRESS_LOCKOUT: lockout_cfg = csr_wdata[9:0];
               CSR_FAST_WINDOW:   window_cfg  = csr_wdata[9:0];
               CSR_FAST_STEP:     fast_cfg    = csr_wdata[6:0];
               CSR_SLOW_STEP:     slow_cfg    = csr_wdata[6:0];
               default: ;
            endcase
         end
         // results first, so one accepted at this edge never meets its own request
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("result with no request outstanding");
               mismatch_count++;
            end else begin
               oldest = expected_levels.pop_front();
               check_field("red_drive", oldest.red_drive, rsp_data.red_drive);
               check_field("green_drive", oldest.green_drive, rsp_data.green_drive);
               check_field("blue_drive", oldest.blue_drive, rsp_data.blue_drive);
               check_field("red_percent", 8'(oldest.red_percent),
                           8'(rsp_data.red_percent));
               check_field("green_percent", 8'(oldest.green_percent),
                           8'(rsp_data.green_percent));
               check_field("blue_percent", 8'(oldest.blue_percent),
                           8'(rsp_data.blue_percent));
               check_field("selected_channel", 8'(oldest.selected_channel),
                           8'(rsp_data.selected_channel));
               check_field("level_changed", 8'(oldest.level_changed),
                           8'(rsp_data.level_changed));
               check_field("selection_changed", 8'(oldest.selection_changed),
                           8'(rsp_data.selection_changed));
            end
         end
         if (req_valid && !req_stall) begin
            apply_tick(req_data, predicted);
            expected_levels.push_back(predicted);
         end
      end
      ticks_pending = expected_levels.size();
   end

endmodule

// File: sim/tb_rotary_encoder_rgb_level_control.sv
`timescale 1ns / 100ps

// Top of the RGB level block test: makes the tick stream, the result-side
// stalls and the register settings. All checking is in rgb_level_checker.
module tb_rotary_encoder_rgb_level_control;
   import rerlc_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_payload_type          req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_payload_type          rsp_data;
   logic                     csr_write_en = 1'b0;
   logic [1:0]               csr_index = CSR_PRESS_LOCKOUT;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int mismatch_count;
   int ticks_pending;

   // steady: no idling on either side; hold_request: ask the receiver for
   // one long hold-off so the output stages fill and req_stall rises
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   // encoder / button pattern state for the random ticks
   logic enc_line = 1'b1;
   logic turn_up = 1'b1;
   int   run_left = 0;
   int   press_left = 0;

   always #10 clock = ~clock;

   rotary_encoder_rgb_level_control dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   rgb_level_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .ticks_pending  (ticks_pending)
   );

   // Offer one tick request and hold it until taken. Called and returning at
   // a falling edge; valid is left high so back-to-back requests never
   // see a low-high pair within one step.
   task automatic send_tick(input logic button, input logic enc_clock,
                            input logic enc_data);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{button_level: button, enc_clock_level: enc_clock,
                     enc_data_level: enc_data};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Mostly proper detents (clock high, then low with data held) with runs
   // short enough for the fast step and long enough for the slow one,
   // occasional button presses of a few ticks, plus some raw noise.
   task automatic send_random_ticks(input int count);
      logic button;
      logic enc_clock;
      logic enc_data;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            enc_line = ~enc_line;
            if (!enc_line && $urandom_range(99) < 30) turn_up = ~turn_up;
            run_left = ($urandom_range(99) < 85) ? $urandom_range(1, 4)
                                                 : $urandom_range(5, 120);
         end
         run_left--;
         if (press_left == 0 && $urandom_range(99) < 3) press_left = $urandom_range(1, 6);
         button = (press_left == 0);
         if (press_left > 0) press_left--;
         enc_clock = enc_line;
         enc_data  = turn_up;
         if ($urandom_range(99) < 12) {button, enc_clock, enc_data} = 3'($urandom_range(7));
         send_tick(button, enc_clock, enc_data);
      end
   endtask

   // Drop valid, let every outstanding result drain, then add spare idle cycles.
   task automatic settle();
      req_valid <= 1'b0;
      while (ticks_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write all four registers on consecutive cycles; enable drops once.
   task automatic load_settings(input logic [9:0] lockout, input logic [9:0] window,
                                input logic [9:0] fast, input logic [9:0] slow);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_PRESS_LOCKOUT;
      csr_wdata    <= lockout;
      @(negedge clock);
      csr_index    <= CSR_FAST_WINDOW;
      csr_wdata    <= window;
      @(negedge clock);
      csr_index    <= CSR_FAST_STEP;
      csr_wdata    <= fast;
      @(negedge clock);
      csr_index    <= CSR_SLOW_STEP;
      csr_wdata    <= slow;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Result side: random stalls, plus one long hold-off on request,
   // counted here while the sender keeps offering ticks.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 11);
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings (lockout 300, window 80, steps 5 / 1).
      send_tick(1'b1, 1'b1, 1'b0);   // idle
      send_tick(1'b0, 1'b1, 1'b0);   // press inside lockout: ignored
      send_tick(1'b1, 1'b0, 1'b0);   // down from zero clamps at zero
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);   // fast step up
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b0, 1'b0, 1'b0);   // all low: no edge, press still locked out
      send_tick(1'b1, 1'b1, 1'b1);   // all high
      send_random_ticks(130);
      settle();

      // No lockout, tiny window, step registers at both extremes; the fast
      // step write carries bits above the register width.
      load_settings(10'd0, 10'd3, 10'h3FF, 10'd0);
      send_tick(1'b0, 1'b1, 1'b1);   // press: green
      send_tick(1'b1, 1'b0, 1'b1);   // outside window: zero step, still an edge
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);   // huge step clamps at 100
      send_tick(1'b0, 1'b1, 1'b0);   // press: blue
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b0, 1'b0, 1'b1);   // press and edge together: red moves
      send_tick(1'b0, 1'b1, 1'b0);   // counter just cleared: press ignored
      send_tick(1'b0, 1'b0, 1'b0);   // press to green, then down to zero
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);   // blue
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);   // wraps back to red
      send_random_ticks(130);
      settle();

      // Lockout at the counter maximum: no press ever taken. Zero window:
      // always the slow step. A long quiet stretch saturates both counters.
      load_settings(10'd1023, 10'd0, 10'd0, 10'd100);
      for (int n = 0; n < 1030; n++) send_tick(1'b1, 1'b1, 1'($urandom_range(1)));
      send_random_ticks(130);
      settle();

      // Widest window; the press counter is still saturated, so the first
      // press goes through. No idling anywhere in this phase.
      steady = 1'b1;
      load_settings(10'd1000, 10'd1023, 10'd100, 10'd1);
      send_random_ticks(130);
      settle();
      steady = 1'b0;

      // Busy mid-range settings, with the long result-side hold-off.
      load_settings(10'd7, 10'd12, 10'd9, 10'd2);
      hold_request = 1'b1;
      send_random_ticks(130);
      settle();

      // Back to the reset values.
      load_settings(10'd300, 10'd80, 10'd5, 10'd1);
      send_random_ticks(130);
      settle();

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
design/rerlc_pkg.sv
design/rerlc_drive_scale.sv
design/rotary_encoder_rgb_level_control.sv
sim/rgb_level_checker.sv
sim/tb_rotary_encoder_rgb_level_control.sv
